/* design/tiep_pkg.sv */
// Package: shared types and constants for the terminal input event parser.
`timescale 1ns / 1ps

package tiep_pkg;

	localparam int EVENT_BYTES = 16;
	localparam int STORE_DEPTH = EVENT_BYTES - 1;
	localparam int LEN_W       = $clog2(EVENT_BYTES);
	localparam int ADDR_W      = $clog2(STORE_DEPTH);

	localparam logic [1:0] MODE_BYTE   = 2'd0;
	localparam logic [1:0] MODE_TICK   = 2'd1;
	localparam logic [1:0] MODE_RESIZE = 2'd2;

	localparam logic [7:0] CH_ESC   = 8'h1b;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DEL   = 8'h7f;
	localparam logic [7:0] CH_O     = 8'h4f;
	localparam logic [7:0] CH_LBRK  = 8'h5b;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_SEMI  = 8'h3b;
	localparam logic [7:0] CH_CARET = 8'h5e;
	localparam logic [7:0] CH_AT    = 8'h40;
	localparam logic [7:0] CH_E     = 8'h65;
	localparam logic [7:0] CH_C     = 8'h63;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_QUEST = 8'h3f;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [15:0] TIMEOUT_RESET = 16'd50;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] data_byte;
	} rx_item_t;

	typedef struct packed {
		logic [7:0] event_byte;
		logic       last;
		logic       dropped;
	} ev_item_t;

	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_ESC  = 4'b0010,
		PH_SEQ  = 4'b0100,
		PH_UTF  = 4'b1000
	} phase_t;

	typedef enum logic [4:0] {
		CT_IDLE  = 5'b00001,
		CT_WR2   = 5'b00010,
		CT_DRAIN = 5'b00100,
		CT_DROP  = 5'b01000,
		CT_RSZ   = 5'b10000
	} ctl_t;

endpackage

/* design/terminal_input_event_parser.sv */
// Top level: terminal byte, tick and resize decoder with a memory-held event buffer.
//
//  channel | direction | payload    | handshake
//  rx      | in        | rx_item_t  | rx_valid / rx_stall
//  ev      | out       | ev_item_t  | ev_valid / ev_stall
//  cfg     | in        | 16b ticks  | cfg_wr_en (no wait)
//
// One item is taken at a time. An item that opens with two bytes writes its second byte
// in the WR2 state; a finished event is then read from the buffer memory one byte a cycle
// while ev is not stalled. A dropped result or a resize emits its result item from the
// DROP or RSZ state.
// Reset clears the control and parse state; the buffer memory needs no clearing.
// A stall on ev holds the output register and pauses draining.
`timescale 1ns / 1ps

module terminal_input_event_parser
	import tiep_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rx_valid,
	output logic        rx_stall,
	input  rx_item_t    rx_item,
	output logic        ev_valid,
	input  logic        ev_stall,
	output ev_item_t    ev_item,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data
);

	logic [7:0]        store_mem [STORE_DEPTH];
	logic [7:0]        rdata_q;
	logic [ADDR_W-1:0] rd_addr;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [7:0]        wr_data;

	ctl_t              ctl_q, ctl_d;
	phase_t            phase_q, phase_d;
	logic [LEN_W-1:0]  len_q, len_d;
	logic [1:0]        cont_q, cont_d;
	logic [15:0]       wait_q, wait_d;
	logic              resize_q, resize_d;
	logic [15:0]       timeout_q;
	logic [LEN_W-1:0]  drain_len_q, drain_len_d;
	logic              rsz_after_q, rsz_after_d;
	logic [7:0]        wr2_byte_q, wr2_byte_d;
	logic              wr2_fin_q, wr2_fin_d;
	logic [LEN_W-1:0]  idx_q;
	logic              ev_valid_q;
	ev_item_t          ev_q;

	logic              accept;
	logic              out_free;
	logic              drain_last;
	logic [7:0]        b;
	logic [7:0]        bs;
	logic [15:0]       wait_inc;
	logic              do_finish;
	logic              do_drop;
	logic              do_two;

	assign accept     = rx_valid && (ctl_q == CT_IDLE);
	assign rx_stall   = (ctl_q != CT_IDLE);
	assign out_free   = !ev_valid_q || !ev_stall;
	assign ev_valid   = ev_valid_q;
	assign ev_item    = ev_q;
	assign drain_last = (idx_q == drain_len_q - LEN_W'(1));
	assign b          = rx_item.data_byte;
	assign bs         = (b == CH_COLON) ? CH_SEMI : b;
	assign wait_inc   = (wait_q == 16'hffff) ? wait_q : wait_q + 16'd1;

	// Read address: advance ahead of the output during drain, park at entry zero otherwise.
	always_comb begin
		if (ctl_q == CT_DRAIN && out_free && !drain_last) begin
			rd_addr = ADDR_W'(idx_q + LEN_W'(1));
		end else if (ctl_q == CT_DRAIN) begin
			rd_addr = ADDR_W'(idx_q);
		end else begin
			rd_addr = '0;
		end
	end

	// Parse decision for the accepted item.
	always_comb begin
		phase_d     = phase_q;
		len_d       = len_q;
		cont_d      = cont_q;
		wait_d      = wait_q;
		resize_d    = resize_q;
		drain_len_d = drain_len_q;
		rsz_after_d = rsz_after_q;
		wr2_byte_d  = wr2_byte_q;
		wr2_fin_d   = wr2_fin_q;
		ctl_d       = ctl_q;
		wr_en       = 1'b0;
		wr_addr     = ADDR_W'(len_q);
		wr_data     = b;
		do_finish   = 1'b0;
		do_drop     = 1'b0;
		do_two      = 1'b0;

		if (accept) begin
			case (rx_item.mode)
				MODE_BYTE: begin
					wait_d = '0;
					case (phase_q)
						PH_ESC: begin
							if (b == CH_O || b == CH_LBRK) begin
								wr_en   = 1'b1;
								len_d   = len_q + LEN_W'(1);
								phase_d = PH_SEQ;
							end else begin
								do_drop = 1'b1;
							end
						end
						PH_SEQ: begin
							if (len_q >= LEN_W'(STORE_DEPTH)) begin
								do_drop = 1'b1;
							end else begin
								wr_en   = 1'b1;
								wr_data = bs;
								len_d   = len_q + LEN_W'(1);
								if (!(bs == CH_SEMI || (bs >= CH_ZERO && bs <= CH_NINE))) begin
									do_finish = 1'b1;
								end
							end
						end
						PH_UTF: begin
							if (b < 8'h80 || b >= 8'hc0) begin
								do_drop = 1'b1;
							end else begin
								wr_en = 1'b1;
								len_d = len_q + LEN_W'(1);
								if (cont_q <= 2'd1) begin
									do_finish = 1'b1;
								end else begin
									cont_d = cont_q - 2'd1;
								end
							end
						end
						default: begin
							wr_en   = 1'b1;
							wr_addr = '0;
							if (b == CH_ESC) begin
								wr_data = CH_E;
								len_d   = LEN_W'(1);
								phase_d = PH_ESC;
							end else if (b < CH_SPACE) begin
								wr_data    = CH_CARET;
								wr2_byte_d = CH_AT + b;
								do_two     = 1'b1;
								wr2_fin_d  = 1'b1;
							end else if (b == CH_DEL) begin
								wr_data    = CH_CARET;
								wr2_byte_d = CH_QUEST;
								do_two     = 1'b1;
								wr2_fin_d  = 1'b1;
							end else if (b < 8'h80) begin
								wr_data    = CH_C;
								wr2_byte_d = b;
								do_two     = 1'b1;
								wr2_fin_d  = 1'b1;
							end else if (b < 8'hc0 || b >= 8'hf8) begin
								wr_en   = 1'b0;
								do_drop = 1'b1;
							end else begin
								wr_data    = CH_C;
								wr2_byte_d = b;
								do_two     = 1'b1;
								wr2_fin_d  = 1'b0;
								phase_d    = PH_UTF;
								len_d      = LEN_W'(2);
								if (b < 8'he0) begin
									cont_d = 2'd1;
								end else if (b < 8'hf0) begin
									cont_d = 2'd2;
								end else begin
									cont_d = 2'd3;
								end
							end
						end
					endcase
				end
				MODE_TICK: begin
					if (phase_q != PH_IDLE) begin
						wait_d = wait_inc;
						if (wait_inc >= timeout_q) begin
							if (phase_q == PH_ESC) begin
								do_finish = 1'b1;
							end else begin
								do_drop = 1'b1;
							end
						end
					end
				end
				MODE_RESIZE: begin
					if (phase_q == PH_IDLE) begin
						resize_d    = 1'b0;
						rsz_after_d = 1'b0;
						ctl_d       = CT_RSZ;
					end else begin
						resize_d = 1'b1;
					end
				end
				default: begin
				end
			endcase

			if (do_two) begin
				ctl_d = CT_WR2;
				if (wr2_fin_d) begin
					drain_len_d = LEN_W'(2);
				end
			end
			// Close the event: the parse state returns to idle at once.
			if (do_finish || do_drop || (do_two && wr2_fin_d)) begin
				if (do_finish) begin
					drain_len_d = len_d;
					ctl_d       = CT_DRAIN;
				end
				if (do_drop) begin
					ctl_d = CT_DROP;
				end
				rsz_after_d = resize_q;
				resize_d    = 1'b0;
				phase_d     = PH_IDLE;
				len_d       = '0;
				cont_d      = '0;
				wait_d      = '0;
			end
		end else begin
			case (ctl_q)
				CT_WR2: begin
					wr_en   = 1'b1;
					wr_addr = ADDR_W'(1);
					wr_data = wr2_byte_q;
					ctl_d   = wr2_fin_q ? CT_DRAIN : CT_IDLE;
				end
				CT_DRAIN: begin
					if (out_free && drain_last) begin
						ctl_d = rsz_after_q ? CT_RSZ : CT_IDLE;
					end
				end
				CT_DROP: begin
					if (out_free) begin
						ctl_d = rsz_after_q ? CT_RSZ : CT_IDLE;
					end
				end
				CT_RSZ: begin
					if (out_free) begin
						ctl_d = CT_IDLE;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_mem[wr_addr] <= wr_data;
		end
		rdata_q <= store_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q       <= CT_IDLE;
			phase_q     <= PH_IDLE;
			len_q       <= '0;
			cont_q      <= '0;
			wait_q      <= '0;
			resize_q    <= 1'b0;
			timeout_q   <= TIMEOUT_RESET;
			drain_len_q <= '0;
			rsz_after_q <= 1'b0;
			wr2_fin_q   <= 1'b0;
			idx_q       <= '0;
			ev_valid_q  <= 1'b0;
		end else begin
			ctl_q       <= ctl_d;
			phase_q     <= phase_d;
			len_q       <= len_d;
			cont_q      <= cont_d;
			wait_q      <= wait_d;
			resize_q    <= resize_d;
			drain_len_q <= drain_len_d;
			rsz_after_q <= rsz_after_d;
			wr2_fin_q   <= wr2_fin_d;
			if (cfg_wr_en) begin
				timeout_q <= cfg_wr_data;
			end
			if (ctl_q != CT_DRAIN) begin
				idx_q <= '0;
			end else if (out_free) begin
				idx_q <= idx_q + LEN_W'(1);
			end
			if ((ctl_q == CT_DRAIN || ctl_q == CT_DROP || ctl_q == CT_RSZ) && out_free) begin
				ev_valid_q <= 1'b1;
			end else if (!ev_stall) begin
				ev_valid_q <= 1'b0;
			end
		end
	end

	// Output payload and the second opening byte carry no reset.
	always_ff @(posedge clk) begin
		wr2_byte_q <= wr2_byte_d;
		if (out_free) begin
			case (ctl_q)
				CT_DRAIN: begin
					ev_q <= '{event_byte: rdata_q, last: drain_last, dropped: 1'b0};
				end
				CT_DROP: begin
					ev_q <= '{event_byte: 8'h00, last: 1'b1, dropped: 1'b1};
				end
				CT_RSZ: begin
					ev_q <= '{event_byte: CH_R, last: 1'b1, dropped: 1'b0};
				end
				default: begin
				end
			endcase
		end
	end

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the terminal input event parser with a scoreboard predictor.
`timescale 1ns / 1ps

module testbench;
	import tiep_pkg::*;

	localparam logic [1:0]  MODE_IGNORED     = 2'd3;
	localparam logic [7:0]  UTF_CONT         = 8'h80;
	localparam logic [7:0]  UTF_LEAD2        = 8'hc0;
	localparam logic [7:0]  UTF_LEAD3        = 8'he0;
	localparam logic [7:0]  UTF_LEAD4        = 8'hf0;
	localparam logic [7:0]  UTF_BAD          = 8'hf8;
	localparam logic [15:0] WAIT_SAT         = 16'hffff;
	localparam int          SETTLE_CYCLES    = 40;
	localparam int          HOLD_OFF_CYCLES  = 300;
	localparam int          EVENTS_PER_PHASE = 3;

	class parser_scoreboard;
		logic [15:0] timeout_ticks;
		phase_t      phase;
		logic [7:0]  text [STORE_DEPTH];
		int          text_len;
		int          conts_left;
		logic [15:0] ticks_waited;
		bit          resize_pending;
		ev_item_t    pending_events [$];
		int          items_noted;
		int          results_checked;
		int          drops_checked;
		int          mismatches;

		function new();
			timeout_ticks = TIMEOUT_RESET;
			phase = PH_IDLE;
			text_len = 0;
			conts_left = 0;
			ticks_waited = '0;
			resize_pending = 1'b0;
			items_noted = 0;
			results_checked = 0;
			drops_checked = 0;
			mismatches = 0;
		endfunction

		function void write_timeout(logic [15:0] value);
			timeout_ticks = value;
		endfunction

		function void emit(logic [7:0] b, bit is_last, bit is_drop);
			ev_item_t e;
			e.event_byte = b;
			e.last = is_last;
			e.dropped = is_drop;
			pending_events.push_back(e);
		endfunction

		function void keep_byte(logic [7:0] b);
			if (text_len < STORE_DEPTH) begin
				text[text_len] = b;
				text_len++;
			end
		endfunction

		function void close_event();
			phase = PH_IDLE;
			text_len = 0;
			conts_left = 0;
			ticks_waited = '0;
			// a resize seen mid-sequence follows the event
			if (resize_pending) begin
				resize_pending = 1'b0;
				emit(CH_R, 1'b1, 1'b0);
			end
		endfunction

		function void finish_event();
			for (int i = 0; i < text_len; i++)
				emit(text[i], (i + 1 == text_len), 1'b0);
			close_event();
		endfunction

		function void drop_event();
			emit(8'h00, 1'b1, 1'b1);
			close_event();
		endfunction

		function void note_rx_item(rx_item_t it);
			logic [7:0] b;
			b = it.data_byte;
			items_noted++;
			case (it.mode)
				MODE_BYTE: begin
					ticks_waited = '0;
					case (phase)
						PH_ESC: begin
							if (b != CH_O && b != CH_LBRK) begin
								drop_event();
							end else begin
								keep_byte(b);
								phase = PH_SEQ;
							end
						end
						PH_SEQ: begin
							if (text_len >= STORE_DEPTH) begin
								drop_event();
							end else begin
								if (b == CH_COLON)
									b = CH_SEMI;
								keep_byte(b);
								if (!(b == CH_SEMI || (b >= CH_ZERO && b <= CH_NINE)))
									finish_event();
							end
						end
						PH_UTF: begin
							if (b < UTF_CONT || b >= UTF_LEAD2) begin
								drop_event();
							end else begin
								keep_byte(b);
								if (conts_left > 0)
									conts_left--;
								if (conts_left == 0)
									finish_event();
							end
						end
						default: begin
							text_len = 0;
							if (b < CH_SPACE && b != CH_ESC) begin
								keep_byte(CH_CARET);
								keep_byte(CH_AT + b);
								finish_event();
							end else if (b == CH_ESC) begin
								keep_byte(CH_E);
								phase = PH_ESC;
							end else if (b == CH_DEL) begin
								keep_byte(CH_CARET);
								keep_byte(CH_QUEST);
								finish_event();
							end else if (b < UTF_CONT) begin
								keep_byte(CH_C);
								keep_byte(b);
								finish_event();
							end else if (b < UTF_LEAD2 || b >= UTF_BAD) begin
								drop_event();
							end else begin
								keep_byte(CH_C);
								keep_byte(b);
								conts_left = (b < UTF_LEAD3) ? 1 : (b < UTF_LEAD4) ? 2 : 3;
								phase = PH_UTF;
							end
						end
					endcase
				end
				MODE_TICK: begin
					if (phase != PH_IDLE) begin
						if (ticks_waited < WAIT_SAT)
							ticks_waited++;
						if (ticks_waited >= timeout_ticks) begin
							if (phase == PH_ESC)
								finish_event();
							else
								drop_event();
						end
					end
				end
				MODE_RESIZE: begin
					if (phase == PH_IDLE) begin
						resize_pending = 1'b0;
						emit(CH_R, 1'b1, 1'b0);
					end else begin
						resize_pending = 1'b1;
					end
				end
				default: ;
			endcase
		endfunction

		function void check_event_item(ev_item_t got);
			ev_item_t want;
			results_checked++;
			if (got.dropped === 1'b1)
				drops_checked++;
			if (pending_events.size() == 0) begin
				mismatches++;
				$display("%0t: expected no result, got byte %h last %b drop %b",
					$time, got.event_byte, got.last, got.dropped);
				return;
			end
			want = pending_events.pop_front();
			if (got.event_byte !== want.event_byte || got.last !== want.last ||
				got.dropped !== want.dropped) begin
				mismatches++;
				$display("%0t: expected byte %h last %b drop %b, got byte %h last %b drop %b",
					$time, want.event_byte, want.last, want.dropped,
					got.event_byte, got.last, got.dropped);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        rx_valid;
	logic        rx_stall;
	rx_item_t    rx_item;
	logic        ev_valid;
	logic        ev_stall;
	ev_item_t    ev_item;
	logic        cfg_wr_en;
	logic [15:0] cfg_wr_data;

	parser_scoreboard sb;
	bit quiet;
	bit hold_req;
	int settings_used;

	terminal_input_event_parser uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx_valid   (rx_valid),
		.rx_stall   (rx_stall),
		.rx_item    (rx_item),
		.ev_valid   (ev_valid),
		.ev_stall   (ev_stall),
		.ev_item    (ev_item),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Both channels are observed on the same edge; inputs first so expectations lead.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rx_valid && !rx_stall)
				sb.note_rx_item(rx_item);
			if (ev_valid && !ev_stall)
				sb.check_event_item(ev_item);
		end
	end

	// Receiver: random stall bursts, plus one long hold-off on request.
	initial begin
		ev_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				ev_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
				ev_stall <= 1'b0;
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				ev_stall <= 1'b1;
				repeat ($urandom_range(1, 8)) @(negedge clk);
				ev_stall <= 1'b0;
			end
		end
	end

	initial begin
		#20_000_000;
		$display("testbench failed");
		$finish;
	end

	task automatic send_item(input logic [1:0] mode, input logic [7:0] b);
		rx_item_t it;
		int gap;
		it.mode = mode;
		it.data_byte = b;
		@(negedge clk);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			rx_valid <= 1'b0;
			gap = $urandom_range(1, 8);
			repeat (gap) @(negedge clk);
		end
		rx_valid <= 1'b1;
		rx_item <= it;
		do @(posedge clk); while (rx_stall);
	endtask

	task automatic tick_n(input int n);
		repeat (n) send_item(MODE_TICK, 8'($urandom));
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_item(MODE_BYTE, s[i]);
	endtask

	// Drop valid, wait for every expected item, then let trailing no-result items finish.
	task automatic settle();
		@(negedge clk);
		rx_valid <= 1'b0;
		while (sb.pending_events.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_timeout(input logic [15:0] value);
		settle();
		cfg_wr_data <= value;
		cfg_wr_en <= 1'b1;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		sb.write_timeout(value);
		settings_used++;
	endtask

	task automatic inner_pause();
		if ($urandom_range(0, 5) == 0)
			tick_n($urandom_range(0, 2));
		if ($urandom_range(0, 9) == 0)
			send_item(MODE_RESIZE, 8'($urandom));
	endtask

	task automatic random_event();
		int kind;
		int n;
		logic [7:0] b;
		kind = $urandom_range(0, 11);
		case (kind)
			0: begin
				if ($urandom_range(0, 7) == 0)
					send_item(MODE_BYTE, CH_DEL);
				else
					send_item(MODE_BYTE, 8'($urandom_range(0, 31)));
			end
			1: send_item(MODE_BYTE, 8'($urandom_range(32, 126)));
			2, 3: begin
				// well-formed UTF-8 with random payload bits
				n = $urandom_range(1, 3);
				b = 8'($urandom);
				case (n)
					1: send_item(MODE_BYTE, {3'b110, b[4:0]});
					2: send_item(MODE_BYTE, {4'b1110, b[3:0]});
					default: send_item(MODE_BYTE, {5'b11110, b[2:0]});
				endcase
				for (int i = 0; i < n; i++) begin
					inner_pause();
					b = 8'($urandom);
					send_item(MODE_BYTE, {2'b10, b[5:0]});
				end
			end
			4, 5, 6: begin
				send_item(MODE_BYTE, CH_ESC);
				inner_pause();
				send_item(MODE_BYTE, ($urandom_range(0, 1) == 0) ? CH_LBRK : CH_O);
				n = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 14) : $urandom_range(0, 4);
				for (int i = 0; i < n; i++) begin
					inner_pause();
					case ($urandom_range(0, 5))
						0: b = CH_SEMI;
						1: b = CH_COLON;
						default: b = CH_ZERO + 8'($urandom_range(0, 9));
					endcase
					send_item(MODE_BYTE, b);
				end
				b = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(64, 126));
				while (b == CH_SEMI || b == CH_COLON || (b >= CH_ZERO && b <= CH_NINE))
					b = 8'($urandom);
				send_item(MODE_BYTE, b);
			end
			7: begin
				n = $urandom_range(1, 3);
				repeat (n) send_item(2'($urandom), 8'($urandom));
			end
			8: begin
				// open a sequence and break it with an arbitrary byte
				if ($urandom_range(0, 1) == 0)
					send_item(MODE_BYTE, CH_ESC);
				else
					send_item(MODE_BYTE, {3'b110, 5'($urandom)});
				tick_n($urandom_range(0, 3));
				send_item(MODE_BYTE, 8'($urandom));
			end
			9: begin
				send_item(MODE_BYTE, ($urandom_range(0, 1) == 0) ? CH_ESC : UTF_LEAD3);
				if ($urandom_range(0, 1) == 0)
					send_item(MODE_BYTE, CH_LBRK);
				tick_n((sb.timeout_ticks > 20) ? 3 : int'(sb.timeout_ticks) + 1);
			end
			10: send_item(MODE_RESIZE, 8'($urandom));
			default: tick_n($urandom_range(1, 3));
		endcase
	endtask

	initial begin
		logic [15:0] phase_timeouts [4];
		rx_valid = 1'b0;
		rx_item = '0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		arst_n = 1'b0;
		quiet = 1'b0;
		hold_req = 1'b0;
		settings_used = 1;
		sb = new();
		phase_timeouts[0] = 16'd1;
		phase_timeouts[1] = 16'd0;
		phase_timeouts[2] = 16'd7;
		phase_timeouts[3] = 16'($urandom_range(3, 20));
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// reset value of the timeout: a lone ESC
		send_item(MODE_BYTE, CH_ESC);
		tick_n(TIMEOUT_RESET);

		set_timeout(16'd2);
		send_item(MODE_BYTE, 8'h00);
		send_item(MODE_BYTE, 8'h1f);
		send_item(MODE_BYTE, CH_DEL);
		send_item(MODE_BYTE, CH_SPACE);
		send_item(MODE_BYTE, 8'h7e);
		send_item(MODE_BYTE, 8'hc3);
		send_item(MODE_BYTE, 8'ha9);
		send_item(MODE_BYTE, 8'he2);
		send_item(MODE_BYTE, 8'h82);
		send_item(MODE_BYTE, 8'hac);
		send_item(MODE_BYTE, 8'hf0);
		send_item(MODE_BYTE, 8'h9f);
		send_item(MODE_BYTE, 8'h98);
		send_item(MODE_BYTE, 8'h80);
		send_item(MODE_BYTE, UTF_CONT);
		send_item(MODE_BYTE, UTF_BAD);
		send_item(MODE_BYTE, 8'hff);
		// bad byte after ESC, then well-formed CSI and SS3 sequences
		send_item(MODE_BYTE, CH_ESC);
		send_text("x");
		send_item(MODE_BYTE, CH_ESC);
		send_text("[1:2A");
		send_item(MODE_BYTE, CH_ESC);
		send_text("OP");
		// lone ESC timing out, then timeouts inside a sequence and a character
		send_item(MODE_BYTE, CH_ESC);
		tick_n(2);
		send_item(MODE_BYTE, CH_ESC);
		send_text("[1");
		tick_n(2);
		send_item(MODE_BYTE, 8'he2);
		send_item(MODE_BYTE, 8'h82);
		tick_n(2);
		// broken character, idle tick, idle resize, ignored mode
		send_item(MODE_BYTE, 8'hc3);
		send_text("A");
		tick_n(1);
		send_item(MODE_RESIZE, 8'hff);
		send_item(MODE_IGNORED, 8'h55);
		// two resizes inside a sequence collapse into one
		send_item(MODE_BYTE, CH_ESC);
		send_item(MODE_RESIZE, 8'h00);
		send_item(MODE_RESIZE, 8'haa);
		send_text("[A");
		// longest event plus a pending resize, then one byte too many
		send_item(MODE_BYTE, CH_ESC);
		send_text("[123456789012");
		send_item(MODE_RESIZE, 8'h00);
		send_text("A");
		send_item(MODE_BYTE, CH_ESC);
		send_text("[1234567890123");
		send_text("X");

		// hold the receiver while the sender keeps the block busy
		settle();
		hold_req = 1'b1;
		repeat (8) send_item(MODE_BYTE, 8'($urandom_range(0, 31)));

		for (int p = 0; p < 4; p++) begin
			set_timeout(phase_timeouts[p]);
			repeat (EVENTS_PER_PHASE) random_event();
		end

		quiet = 1'b1;
		set_timeout(WAIT_SAT);
		send_item(MODE_BYTE, CH_ESC);
		repeat (EVENTS_PER_PHASE) random_event();
		settle();

		$display("Run covered %0d input items over %0d timeout settings.",
			sb.items_noted, settings_used);
		$display("Checked %0d result items, %0d of them dropped events.",
			sb.results_checked, sb.drops_checked);
		if (sb.mismatches == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
